// ===== design/btke_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btke_pkg
// Shared types and constants of the typematic key event generator.
// ----------------------------------------------------------------------------
package btke_pkg;

	localparam int ButtonBits = 16;
	localparam int IdxW       = 4;
	localparam int TickW      = 32;
	localparam int IvlW       = 16;

	localparam logic [IdxW-1:0] SkipLo  = 4'd10;
	localparam logic [IdxW-1:0] SkipHi  = 4'd11;
	localparam logic [IdxW-1:0] LastIdx = 4'd15;

	// configuration register indexes
	localparam logic CfgEventsEnable = 1'b0;
	localparam logic CfgRepeatIvl    = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic            load;
		logic            step;
		logic            flush;
		logic [IdxW-1:0] idx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic enable;
		logic evt;
		logic pend_v;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== design/btke_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btke_in_if / btke_out_if
// Valid/ready channels for polls and for key events.
// ----------------------------------------------------------------------------
interface btke_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] buttons;
	logic        packet_advanced;
	logic [31:0] now_ms;

	modport source (output valid, buttons, packet_advanced, now_ms, input ready);
	modport sink   (input valid, buttons, packet_advanced, now_ms, output ready);
endinterface

interface btke_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] button_index;
	logic       is_release;
	logic       was_held;
	logic       last;

	modport source (output valid, button_index, is_release, was_held, last, input ready);
	modport sink   (input valid, button_index, is_release, was_held, last, output ready);
endinterface
`default_nettype wire

// ===== design/btke_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btke_ctrl
// Sequencer: accepts a poll and, with events enabled, walks the button positions and flushes the last event.
// ----------------------------------------------------------------------------
module btke_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire btke_pkg::sts_t sts,
	output btke_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		StIdle  = 3'b001,
		StWalk  = 3'b010,
		StFlush = 3'b100
	} state_t;

	state_t                     state_q, state_d;
	logic [btke_pkg::IdxW-1:0]  idx_q;
	logic                       step;
	logic                       flush_done;

	assign in_ready   = (state_q == StIdle);
	// a new event may only displace a pending one if the output can take it
	assign step       = (state_q == StWalk) && (!sts.evt || !sts.pend_v || sts.out_free);
	assign flush_done = (state_q == StFlush) && (!sts.pend_v || sts.out_free);

	always_comb begin
		cmd.load  = in_valid && in_ready;
		cmd.step  = step;
		cmd.flush = flush_done && sts.pend_v;
		cmd.idx   = idx_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			StIdle: begin
				if (in_valid && sts.enable) state_d = StWalk;
			end
			StWalk: begin
				if (step && idx_q == btke_pkg::LastIdx) state_d = StFlush;
			end
			StFlush: begin
				if (flush_done) state_d = StIdle;
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) idx_q <= '0;
			else if (step) idx_q <= idx_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== design/btke_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btke_dp
// Datapath: configuration and poll registers, press records, repeat compare, pending and output
// event registers.
// ----------------------------------------------------------------------------
module btke_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic           cfg_index,
	input  wire logic [15:0]    cfg_data,
	btke_in_if.sink             in_ch,
	btke_out_if.source          out_ch,
	input  wire btke_pkg::cmd_t cmd,
	output btke_pkg::sts_t      sts
);

	localparam int Bits = btke_pkg::ButtonBits;

	logic                        enable_q;
	logic [btke_pkg::IvlW-1:0]   ivl_q;
	logic [Bits-1:0]             prev_q;
	logic [Bits-1:0]             walk_prev_q;
	logic [Bits-1:0]             cur_q;
	logic                        adv_q;
	logic [btke_pkg::TickW-1:0]  now_q;
	logic [btke_pkg::TickW-1:0]  tick_q [Bits];
	logic [Bits-1:0]             valid_q;

	logic                        pend_v_q;
	logic [btke_pkg::IdxW-1:0]   pend_idx_q;
	logic                        pend_rel_q;
	logic                        pend_held_q;

	logic                        out_v_q;
	logic [btke_pkg::IdxW-1:0]   out_idx_q;
	logic                        out_rel_q;
	logic                        out_held_q;
	logic                        out_last_q;

	logic                        down, was, skip, fire;
	logic                        key_dn, key_up, evt;
	logic [btke_pkg::TickW-1:0]  elapsed;
	logic                        out_free, move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			ivl_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				btke_pkg::CfgEventsEnable: enable_q <= cfg_data[0];
				btke_pkg::CfgRepeatIvl:    ivl_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// event decision for the position under the walk pointer
	always_comb begin
		down    = cur_q[cmd.idx];
		was     = walk_prev_q[cmd.idx];
		skip    = (cmd.idx == btke_pkg::SkipLo) || (cmd.idx == btke_pkg::SkipHi);
		elapsed = now_q - tick_q[cmd.idx];
		fire    = !valid_q[cmd.idx]
			|| ((ivl_q != '0) && (elapsed >= {{(btke_pkg::TickW-btke_pkg::IvlW){1'b0}}, ivl_q}))
			|| ((ivl_q == '0) && !was);
		key_dn  = !skip && down && fire;
		key_up  = !skip && adv_q && !down && was;
		evt     = key_dn || key_up;
	end

	assign out_free = !out_v_q || out_ch.ready;
	assign move     = (cmd.step && evt && pend_v_q) || cmd.flush;

	always_comb begin
		sts.enable   = enable_q;
		sts.evt      = evt;
		sts.pend_v   = pend_v_q;
		sts.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (cmd.load) begin
			prev_q <= in_ch.buttons;
		end
	end

	// snapshot the poll; the walk sees the word from before it
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			walk_prev_q <= prev_q;
			cur_q       <= in_ch.buttons;
			adv_q       <= in_ch.packet_advanced;
			now_q       <= in_ch.now_ms;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && key_dn) tick_q[cmd.idx] <= now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.step) begin
			if (key_dn) valid_q[cmd.idx] <= 1'b1;
			else if (key_up) valid_q[cmd.idx] <= 1'b0;
		end
	end

	// hold one event back so the final one of a poll can be marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (cmd.step && evt) begin
			pend_v_q <= 1'b1;
		end else if (cmd.flush) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && evt) begin
			pend_idx_q  <= cmd.idx;
			pend_rel_q  <= key_up;
			pend_held_q <= key_dn && was;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_idx_q  <= pend_idx_q;
			out_rel_q  <= pend_rel_q;
			out_held_q <= pend_held_q;
			out_last_q <= cmd.flush;
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.button_index = out_idx_q;
	assign out_ch.is_release   = out_rel_q;
	assign out_ch.was_held     = out_held_q;
	assign out_ch.last         = out_last_q;

endmodule
`default_nettype wire

// ===== design/button_typematic_key_events.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// button_typematic_key_events
// Turns polled button words into key-down, auto-repeat and key-up events.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one poll per transaction: button word, packet-advanced flag
//   and millisecond tick. out_ch carries one key event per transaction, in
//   ascending button order, with last set on the final event of a poll.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle:
//   index 0 enables events, index 1 sets the repeat interval in ticks.
//   With events enabled a poll is accepted, then each button position is stepped
//   through the single tick compare in ascending order, and the held-back final
//   event is flushed. With events disabled a poll is accepted and only updates
//   the stored word. An event enters the output register when the next event
//   of the same poll is found; the final one enters at the flush. When the
//   receiver stalls, the walk stops at the next event that would need the
//   output register; the next poll is accepted once the final event sits in
//   the output register, even if it has not been taken yet.
//   Reset clears the configuration, the previous word and all press records.
// ----------------------------------------------------------------------------
module button_typematic_key_events (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	btke_in_if.sink          in_ch,
	btke_out_if.source       out_ch
);

	btke_pkg::cmd_t cmd;
	btke_pkg::sts_t sts;
	logic           in_ready;

	btke_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign in_ch.ready = in_ready;

	btke_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef NO_ASSERTIONS
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sts.pend_v)
		else $error("event still pending while accepting a poll");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.flush}))
		else $error("more than one command in a cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sts.evt && sts.pend_v) || cmd.flush |-> sts.out_free)
		else $error("output event overwritten before transaction");
`endif

endmodule
`default_nettype wire
